// ===== src/rfp_pkg.sv =====
// Package for the response frame parser: frame constants, register map,
// configuration, status and result types. No dependencies.

package rfp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned PosW       = 4;
  localparam int unsigned SumW       = 16;
  localparam int unsigned ParamW     = 32;
  localparam int unsigned ErrW       = 5;
  localparam int unsigned ParamBytes = 4;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [ByteW-1:0] AckCode   = 8'h30;
  localparam logic [ByteW-1:0] NakCode   = 8'h31;
  localparam logic [ByteW-1:0] LastError = 8'h12;
  localparam logic [ErrW-1:0]  InvalidError = 5'd19;

  // Frame byte positions
  localparam logic [PosW-1:0] PosHunt     = 4'd0;
  localparam logic [PosW-1:0] PosStart2   = 4'd1;
  localparam logic [PosW-1:0] PosIdLow    = 4'd2;
  localparam logic [PosW-1:0] PosIdHigh   = 4'd3;
  localparam logic [PosW-1:0] PosParam0   = 4'd4;
  localparam logic [PosW-1:0] PosParam1   = 4'd5;
  localparam logic [PosW-1:0] PosParam2   = 4'd6;
  localparam logic [PosW-1:0] PosParam3   = 4'd7;
  localparam logic [PosW-1:0] PosAckByte  = 4'd8;
  localparam logic [PosW-1:0] PosZeroByte = 4'd9;
  localparam logic [PosW-1:0] PosSumLow   = 4'd10;
  localparam logic [PosW-1:0] PosSumHigh  = 4'd11;
  localparam logic [PosW-1:0] FrameBytes  = 4'd12;

  typedef enum logic [1:0] {
    RegStartOne = 2'd0,
    RegStartTwo = 2'd1,
    RegIdLow    = 2'd2,
    RegIdHigh   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] start_code_one;
    logic [ByteW-1:0] start_code_two;
    logic [ByteW-1:0] device_id_low;
    logic [ByteW-1:0] device_id_high;
  } cfg_t;

  typedef struct packed {
    logic ack;
    logic [ParamW-1:0] param_value;
    logic [ErrW-1:0]   error_code;
    logic header_ok;
    logic ack_byte_ok;
    logic checksum_ok;
  } result_t;

  typedef struct packed {
    logic hunting;  // engine waits for the start byte
    logic last;     // current byte closes the frame
  } eng_status_t;

endpackage

// ===== src/rfp_stream_if.sv =====
// Valid/ready channels of the response frame parser: received bytes in,
// decoded results out. Depends on rfp_pkg.

interface rfp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [rfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfp_result_if;
  logic                       valid;
  logic                       ready;
  logic                       ack;
  logic [rfp_pkg::ParamW-1:0] param_value;
  logic [rfp_pkg::ErrW-1:0]   error_code;
  logic                       header_ok;
  logic                       ack_byte_ok;
  logic                       checksum_ok;

  modport source (output valid, output ack, output param_value, output error_code,
                  output header_ok, output ack_byte_ok, output checksum_ok,
                  input ready);
  modport sink   (input valid, input ack, input param_value, input error_code,
                  input header_ok, input ack_byte_ok, input checksum_ok,
                  output ready);
endinterface

// ===== src/rfp_cfg_regs.sv =====
// APB register file of the response frame parser: start codes and device ID.
// Depends on rfp_pkg.

module rfp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rfp_pkg::ApbDataW-1:0]  pwdata,
  output logic [rfp_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output rfp_pkg::cfg_t                 cfg_o
);
  import rfp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegStartOne: cfg_d.start_code_one = pwdata[ByteW-1:0];
        RegStartTwo: cfg_d.start_code_two = pwdata[ByteW-1:0];
        RegIdLow:    cfg_d.device_id_low  = pwdata[ByteW-1:0];
        RegIdHigh:   cfg_d.device_id_high = pwdata[ByteW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegStartOne: prdata[ByteW-1:0] = cfg_q.start_code_one;
      RegStartTwo: prdata[ByteW-1:0] = cfg_q.start_code_two;
      RegIdLow:    prdata[ByteW-1:0] = cfg_q.device_id_low;
      RegIdHigh:   prdata[ByteW-1:0] = cfg_q.device_id_high;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code_one <= 8'h55;
      cfg_q.start_code_two <= 8'hAA;
      cfg_q.device_id_low  <= 8'h01;
      cfg_q.device_id_high <= 8'h00;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/rfp_frame_engine.sv =====
// Frame tracking and per-byte checks of the response frame parser: byte
// position, running sum, captured fields and check flags. Depends on rfp_pkg.

module rfp_frame_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [rfp_pkg::ByteW-1:0] byte_i,
  input  rfp_pkg::cfg_t             cfg_i,
  output rfp_pkg::result_t          res_o,
  output rfp_pkg::eng_status_t      status_o
);
  import rfp_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0] param_q [ParamBytes];
  logic [ByteW-1:0] ack_code_q;
  logic [2:0]       flags_q, flags_d;
  logic             hunting;

  assign hunting = (pos_q == PosHunt) || (pos_q >= FrameBytes);

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    flags_d = flags_q;
    if (hunting) begin
      if (byte_i == cfg_i.start_code_one) begin
        pos_d   = PosStart2;
        sum_d   = {{(SumW-ByteW){1'b0}}, byte_i};
        flags_d = 3'b111;
      end else begin
        pos_d = PosHunt;
      end
    end else begin
      case (pos_q)
        PosStart2: if (byte_i != cfg_i.start_code_two) flags_d[0] = 1'b0;
        PosIdLow:  if (byte_i != cfg_i.device_id_low)  flags_d[0] = 1'b0;
        PosIdHigh: if (byte_i != cfg_i.device_id_high) flags_d[0] = 1'b0;
        PosAckByte: begin
          if (byte_i != AckCode && byte_i != NakCode) flags_d[1] = 1'b0;
        end
        PosZeroByte: if (byte_i != '0) flags_d[1] = 1'b0;
        PosSumLow:   if (byte_i != sum_q[ByteW-1:0]) flags_d[2] = 1'b0;
        PosSumHigh:  if (byte_i != sum_q[SumW-1:ByteW]) flags_d[2] = 1'b0;
        default:     flags_d = flags_q;
      endcase
      if (pos_q < PosSumLow) sum_d = sum_q + {{(SumW-ByteW){1'b0}}, byte_i};
      pos_d = (pos_q == PosSumHigh) ? PosHunt : pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      sum_q   <= '0;
      flags_q <= 3'b111;
    end else if (step_i) begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      flags_q <= flags_d;
    end
  end

  // Captured payload: written within the frame before it is read
  always_ff @(posedge clk_i) begin
    if (step_i && !hunting) begin
      if (pos_q == PosParam0) param_q[0] <= byte_i;
      if (pos_q == PosParam1) param_q[1] <= byte_i;
      if (pos_q == PosParam2) param_q[2] <= byte_i;
      if (pos_q == PosParam3) param_q[3] <= byte_i;
      if (pos_q == PosAckByte) ack_code_q <= byte_i;
    end
  end

  always_comb begin
    res_o.ack         = (ack_code_q == AckCode);
    res_o.param_value = {param_q[3], param_q[2], param_q[1], param_q[0]};
    if (param_q[1] == '0 || param_q[0] > LastError) begin
      res_o.error_code = InvalidError;
    end else begin
      res_o.error_code = param_q[0][ErrW-1:0];
    end
    res_o.header_ok   = flags_d[0];
    res_o.ack_byte_ok = flags_d[1];
    res_o.checksum_ok = flags_d[2];
  end

  assign status_o.hunting = hunting;
  assign status_o.last    = (pos_q == PosSumHigh);

endmodule

// ===== src/response_frame_parser_core.sv =====
// Top level of the response frame parser: byte input register, frame engine,
// result register and APB configuration. Depends on rfp_pkg, rfp_stream_if, rfp_cfg_regs and rfp_frame_engine.

// Receives one serial byte per transfer on rx_i and emits one decoded result
// on res_o per 12-byte response frame. Bytes are dropped until one equals
// start_code_one; that byte and the next eleven form the frame. Bytes 1-3
// are checked against start_code_two and the device ID, byte 8 must be ack
// (0x30) or nak (0x31), byte 9 zero, and bytes 10-11 the wrapping 16-bit sum
// of bytes 0-9 (low byte first). A failed check still yields a result, with
// its flag low. A start code inside a frame is plain data. The block takes
// one byte per clock unless rx_i is stalled: a byte lands in an input
// register, is checked and folded into the frame state when it advances,
// and the twelfth byte loads the result register at that same edge, so a
// result is offered from the result register once its last byte advances.
// The result register parts the two sides: input
// transfers continue while a result waits, and only a frame-closing byte
// held behind an untaken result stalls rx_i. Configuration registers sit on
// an APB port at byte addresses 0, 4, 8 and 12 (start_code_one,
// start_code_two, device_id_low, device_id_high); write them while no frame
// is in progress.

module response_frame_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rfp_byte_if.sink                      rx_i,
  rfp_result_if.source                  res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rfp_pkg::ApbDataW-1:0]  pwdata,
  output logic [rfp_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import rfp_pkg::*;

  cfg_t        cfg;
  result_t     eng_res;
  eng_status_t eng_status;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q;
  logic             advance;

  rfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfp_frame_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .cfg_i    (cfg),
    .res_o    (eng_res),
    .status_o (eng_status)
  );

  // Advance the held byte unless it closes a frame and the result slot is
  // still occupied by an untaken result.
  assign advance = in_valid_q && (!eng_status.last || !out_valid_q || res_o.ready);

  assign rx_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_i.valid && rx_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && eng_status.last) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold until replaced
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) in_byte_q <= rx_i.rx_byte;
    if (advance && eng_status.last) out_res_q <= eng_res;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.ack         = out_res_q.ack;
  assign res_o.param_value = out_res_q.param_value;
  assign res_o.error_code  = out_res_q.error_code;
  assign res_o.header_ok   = out_res_q.header_ok;
  assign res_o.ack_byte_ok = out_res_q.ack_byte_ok;
  assign res_o.checksum_ok = out_res_q.checksum_ok;

`ifndef ASSERT_OFF
  // A frame-closing byte must always land in the result register
  a_last_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && eng_status.last |=> out_valid_q)
    else $error("closing byte advanced but no result was loaded");

  // A held byte is never lost or altered while it waits
  a_held_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("held input byte was dropped or overwritten");

  // The frame cannot close while the engine is hunting
  a_last_not_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_status.last |-> !eng_status.hunting)
    else $error("frame end flagged while hunting");
`endif

endmodule
